// ===== design/lstk_pkg.sv =====
// Shared types and codes for the keyed-remove LIFO stack.
package lstk_pkg;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_REMOVE = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      cmp_en;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    FSM_IDLE   = 3'b001,
    FSM_CMP    = 3'b010,
    FSM_COMMIT = 3'b100
  } fsm_state_e;

endpackage

// ===== design/lstk_cell.sv =====
// One stack cell: holds a key, compares it against the broadcast key, shifts to neighbors.
module lstk_cell import lstk_pkg::*; #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                clk_i,
  input  cell_ctl_t           ctl_i,
  input  logic [KEY_BITS-1:0] cmp_key_i,
  input  logic [KEY_BITS-1:0] prev_key_i,
  input  logic [KEY_BITS-1:0] next_key_i,
  output logic [KEY_BITS-1:0] key_o,
  output logic                match_o
);

  logic [KEY_BITS-1:0] key_q, key_d;
  logic                match_q;

  always_comb begin
    case (ctl_i.cmd)
      CELL_FROM_PREV: key_d = prev_key_i;
      CELL_FROM_NEXT: key_d = next_key_i;
      default:        key_d = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (ctl_i.cmp_en) begin
      match_q <= (key_q == cmp_key_i);
    end
  end

  assign key_o   = key_q;
  assign match_o = match_q;

endmodule

// ===== design/lifo_stack_with_keyed_remove.sv =====
// Top level of the bounded LIFO key stack with search and keyed remove.
// An item is accepted only while the block is idle. In the next cycle every cell compares its
// key with the request key; in the commit state that follows, the row of cells shifts and the
// result register is loaded, which makes the result item valid. The input becomes ready again
// in the cycle after the commit, so the block takes no new item until the accept, compare and
// commit sequence through the cell row is done.
// The commit waits, and the input stays blocked, for as long as the previous result item is
// still held by a stalled receiver. The top of the stack sits in cell 0; push shifts the row
// away from it, pop and remove shift toward it.
module lifo_stack_with_keyed_remove import lstk_pkg::*; #(
  parameter int unsigned DEPTH    = 8,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [63:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] out_key_o,
  output logic        found_o,
  output logic [3:0]  entries_o,
  output logic        is_full_o,
  output logic        is_empty_o
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned LVLS = $clog2(DEPTH);

  fsm_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic out_valid_q;
  op_kind_e op_kind_q;
  logic [KEY_BITS-1:0] op_key_q;

  logic [1:0]  status_q;
  logic [63:0] out_key_q;
  logic        found_q;
  logic [CW-1:0] entries_q;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    cell_match;
  cell_ctl_t           cell_ctl [DEPTH];
  logic [DEPTH-1:0]    pfx [LVLS+1];

  logic commit, full, empty, any_hit;
  logic push_go, pop_go, rm_go;
  status_e status_d;
  logic found_d;
  logic [KEY_BITS+63:0] top_ext;
  logic [CW+3:0] entries_ext;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign commit     = (state_q == FSM_COMMIT) && (!out_valid_q || out_ready_i);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  // Prefix OR from the top: bit i is set when a live cell at or above i matched.
  genvar gi, gl;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_occ
      assign pfx[0][gi] = cell_match[gi] && (count_q > CW'(gi));
    end
    for (gl = 0; gl < LVLS; gl++) begin : g_lvl
      for (gi = 0; gi < DEPTH; gi++) begin : g_bit
        if (gi >= (1 << gl)) begin : g_or
          assign pfx[gl+1][gi] = pfx[gl][gi] | pfx[gl][gi-(1<<gl)];
        end else begin : g_cp
          assign pfx[gl+1][gi] = pfx[gl][gi];
        end
      end
    end
  endgenerate

  assign any_hit = pfx[LVLS][DEPTH-1];

  always_comb begin
    push_go  = 1'b0;
    pop_go   = 1'b0;
    rm_go    = 1'b0;
    status_d = ST_OK;
    found_d  = 1'b0;
    count_d  = count_q;
    case (op_kind_q)
      OP_PUSH: begin
        if (full) status_d = ST_FULL;
        else begin
          push_go = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      OP_POP: begin
        if (empty) status_d = ST_EMPTY;
        else begin
          pop_go  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      OP_SEARCH: begin
        if (any_hit) found_d = 1'b1;
        else status_d = ST_NOT_FOUND;
      end
      default: begin
        if (empty) status_d = ST_EMPTY;
        else if (!any_hit) status_d = ST_NOT_FOUND;
        else begin
          found_d = 1'b1;
          rm_go   = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
    endcase
  end

  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_BITS-1:0] prev_key, next_key;

      always_comb begin
        cell_ctl[gi].cmp_en = (state_q == FSM_CMP);
        if (commit && push_go) cell_ctl[gi].cmd = CELL_FROM_PREV;
        else if (commit && (pop_go || (rm_go && pfx[LVLS][gi])))
          cell_ctl[gi].cmd = CELL_FROM_NEXT;
        else cell_ctl[gi].cmd = CELL_HOLD;
      end

      if (gi == 0) begin : g_first
        assign prev_key = op_key_q;
      end else begin : g_mid_p
        assign prev_key = cell_key[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign next_key = cell_key[gi];
      end else begin : g_mid_n
        assign next_key = cell_key[gi+1];
      end

      lstk_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk_i      (clk_i),
        .ctl_i      (cell_ctl[gi]),
        .cmp_key_i  (op_key_q),
        .prev_key_i (prev_key),
        .next_key_i (next_key),
        .key_o      (cell_key[gi]),
        .match_o    (cell_match[gi])
      );
    end
  endgenerate

  assign top_ext = {64'd0, cell_key[0]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:   if (in_valid_i) state_d = FSM_CMP;
      FSM_CMP:    state_d = FSM_COMMIT;
      FSM_COMMIT: if (commit) state_d = FSM_IDLE;
      default:    state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_kind_q <= op_kind_e'(kind_i);
      op_key_q  <= key_i[KEY_BITS-1:0];
    end
    if (commit) begin
      status_q  <= status_d;
      out_key_q <= pop_go ? top_ext[63:0] : 64'd0;
      found_q   <= found_d;
      entries_q <= count_d;
    end
  end

  assign entries_ext = {4'd0, entries_q};

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_key_o   = out_key_q;
  assign found_o     = found_q;
  assign entries_o   = entries_ext[3:0];
  assign is_full_o   = (entries_q == CW'(DEPTH));
  assign is_empty_o  = (entries_q == '0);

endmodule

// ===== design/lstk_checker.sv =====
// Port-level checks for the keyed-remove LIFO stack, bound to the top level.
module lstk_checker import lstk_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  kind_i,
  input logic [63:0] key_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] out_key_o,
  input logic        found_o,
  input logic [3:0]  entries_o,
  input logic        is_full_o,
  input logic        is_empty_o
);

  // A waiting result item must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_key_o) && $stable(status_o))
    else $error("result item changed while stalled");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_full_o && is_empty_o))
    else $error("stack reported both full and empty");

  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> is_full_o && !found_o)
    else $error("push refused while stack not full");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> is_empty_o && out_key_o == 64'd0)
    else $error("empty status with stored entries");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> status_o == ST_OK)
    else $error("match reported with error status");

endmodule

bind lifo_stack_with_keyed_remove lstk_checker u_lstk_checker (.*);
